@@ rtl/core/assert_macros.svh @@
// Assertion shorthands for the RTL files (included by quaternion_accumulate_renorm.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/qar_pkg.sv @@
// Shared types, constants and the product-term table for the quaternion accumulator
`timescale 1ns / 1ps
`default_nettype none

package qar_pkg;

  localparam int Q_W           = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int INTERVAL_W    = 7;
  localparam int ACC_W         = 35;  // four 16x16 products plus rounding
  localparam int MAG2_W        = 33;  // sum of four squares
  localparam int ROOT_W        = 17;
  localparam int QUO_W         = 17;
  localparam int Q_MAX         = 32767;
  localparam int Q_MIN         = -32768;

  localparam logic [INTERVAL_W-1:0] RENORM_RESET = 7'd97;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic valid;
    logic clear;
    logic neg;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0] ci;
    logic [1:0] di;
    logic       neg;
  } term_t;

  // {component, term}: product c[ci]*d[di], subtracted when neg
  function automatic term_t term_sel(input logic [3:0] ik);
    term_t t;
    unique case (ik)
      4'd0:  t = '{ci: 2'd3, di: 2'd0, neg: 1'b0};
      4'd1:  t = '{ci: 2'd0, di: 2'd3, neg: 1'b0};
      4'd2:  t = '{ci: 2'd1, di: 2'd2, neg: 1'b0};
      4'd3:  t = '{ci: 2'd2, di: 2'd1, neg: 1'b1};
      4'd4:  t = '{ci: 2'd3, di: 2'd1, neg: 1'b0};
      4'd5:  t = '{ci: 2'd1, di: 2'd3, neg: 1'b0};
      4'd6:  t = '{ci: 2'd2, di: 2'd0, neg: 1'b0};
      4'd7:  t = '{ci: 2'd0, di: 2'd2, neg: 1'b1};
      4'd8:  t = '{ci: 2'd3, di: 2'd2, neg: 1'b0};
      4'd9:  t = '{ci: 2'd2, di: 2'd3, neg: 1'b0};
      4'd10: t = '{ci: 2'd0, di: 2'd1, neg: 1'b0};
      4'd11: t = '{ci: 2'd1, di: 2'd0, neg: 1'b1};
      4'd12: t = '{ci: 2'd3, di: 2'd3, neg: 1'b0};
      4'd13: t = '{ci: 2'd0, di: 2'd0, neg: 1'b1};
      4'd14: t = '{ci: 2'd1, di: 2'd1, neg: 1'b1};
      4'd15: t = '{ci: 2'd2, di: 2'd2, neg: 1'b1};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/qar_ifs.sv @@
// Valid/ready channel interfaces: increment in, orientation out, interval config
`timescale 1ns / 1ps
`default_nettype none

interface qar_in_if;
  import qar_pkg::*;
  logic valid;
  logic ready;
  q_t   delta_x;
  q_t   delta_y;
  q_t   delta_z;
  q_t   delta_w;
  modport source (output valid, delta_x, delta_y, delta_z, delta_w, input ready);
  modport sink   (input valid, delta_x, delta_y, delta_z, delta_w, output ready);
endinterface

interface qar_out_if;
  import qar_pkg::*;
  logic valid;
  logic ready;
  q_t   orient_x;
  q_t   orient_y;
  q_t   orient_z;
  q_t   orient_w;
  logic renormalized;
  logic saturated;
  modport source (output valid, orient_x, orient_y, orient_z, orient_w, renormalized,
                  saturated, input ready);
  modport sink   (input valid, orient_x, orient_y, orient_z, orient_w, renormalized,
                  saturated, output ready);
endinterface

interface qar_cfg_if;
  import qar_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] renorm_interval;
  modport source (output valid, renorm_interval, input ready);
  modport sink   (input valid, renorm_interval, output ready);
endinterface

`default_nettype wire

@@ rtl/core/qar_mac.sv @@
// Shared signed 16x16 multiplier with registered product and add/subtract accumulator
`timescale 1ns / 1ps
`default_nettype none

module qar_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire qar_pkg::mac_ctl_t                ctl,
  input  wire logic signed [qar_pkg::Q_W-1:0]   a,
  input  wire logic signed [qar_pkg::Q_W-1:0]   b,
  output logic signed [qar_pkg::ACC_W-1:0]      acc,
  output logic                                  done
);
  import qar_pkg::*;

  localparam int P_W = 2 * Q_W;

  logic signed [P_W-1:0]   prod_r;
  mac_ctl_t                ctl_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] term;
  logic                    done_r;

  assign base = ctl_r.clear ? '0 : acc_r;
  assign term = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl;
      done_r <= ctl_r.valid & ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (ctl_r.valid) begin
      acc_r <= ctl_r.neg ? base - term : base + term;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/core/qar_isqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module qar_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [qar_pkg::MAG2_W-1:0]    radicand,
  output logic                               busy,
  output logic                               done,
  output logic [qar_pkg::ROOT_W-1:0]         root
);
  import qar_pkg::*;

  // highest even power of two that fits the radicand
  localparam logic [MAG2_W-1:0] FIRST_BIT = MAG2_W'(1) << (2 * ((MAG2_W - 1) / 2));

  logic [MAG2_W-1:0] n_r;
  logic [MAG2_W-1:0] res_r;
  logic [MAG2_W-1:0] bit_r;
  logic              busy_r;
  logic              done_r;
  logic [MAG2_W:0]   cand;
  logic              ge;

  assign cand = {1'b0, res_r} + {1'b0, bit_r};
  assign ge   = {1'b0, n_r} >= cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= FIRST_BIT;
    end else if (busy_r) begin
      if (ge) begin
        n_r   <= n_r - cand[MAG2_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/qar_div.sv @@
// Restoring divider: component * 2^FRAC_BITS / magnitude, rounded half away from zero, clipped
`timescale 1ns / 1ps
`default_nettype none

module qar_div #(
  parameter int FRAC_BITS = qar_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [qar_pkg::Q_W-1:0]    num,
  input  wire logic [qar_pkg::ROOT_W-1:0]        mag,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [qar_pkg::Q_W-1:0]         res,
  output logic                                   sat
);
  import qar_pkg::*;

  localparam int DW     = ROOT_W + FRAC_BITS;  // 2*|num|*2^F + mag
  localparam int VW     = ROOT_W + 1;          // 2*mag
  localparam int CW     = ((FRAC_BITS > VW) ? FRAC_BITS : VW) + 1;
  localparam int STEP_W = $clog2(QUO_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W);
  localparam logic [QUO_W-1:0]  POS_LIM   = QUO_W'(Q_MAX);
  localparam logic [QUO_W-1:0]  NEG_LIM   = QUO_W'(-Q_MIN);

  logic [Q_W-1:0]    num_abs;
  logic [DW-1:0]     dividend;
  logic [VW-1:0]     divisor;
  logic [CW-1:0]     hi;
  logic [VW-1:0]     v_r;
  logic [VW-1:0]     rem_r;
  logic [QUO_W-1:0]  low_r;
  logic [QUO_W-1:0]  quo_r;
  logic              neg_r;
  logic              ovf_r;
  logic [STEP_W-1:0] stp_r;
  logic              busy_r;
  logic              done_r;
  q_t                res_r;
  logic              sat_r;
  logic [VW:0]       rem2;
  logic              ge;
  q_t                fin_res;
  logic              fin_sat;

  assign num_abs  = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
  assign dividend = (DW'(num_abs) << (FRAC_BITS + 1)) + DW'(mag);
  assign divisor  = {mag, 1'b0};
  assign hi       = CW'(dividend >> QUO_W);

  assign rem2 = {rem_r, low_r[QUO_W-1]};
  assign ge   = rem2 >= {1'b0, v_r};

  always_comb begin
    if (neg_r) begin
      fin_sat = ovf_r || (quo_r > NEG_LIM);
      fin_res = fin_sat ? q_t'(Q_MIN) : Q_W'(-quo_r);
    end else begin
      fin_sat = ovf_r || (quo_r > POS_LIM);
      fin_res = fin_sat ? q_t'(Q_MAX) : quo_r[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      stp_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        stp_r  <= '0;
      end else if (busy_r) begin
        if (stp_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          stp_r <= stp_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= divisor;
      neg_r <= num[Q_W-1];
      // quotient would not fit in QUO_W bits: result clips anyway
      ovf_r <= hi >= CW'(divisor);
      rem_r <= hi[VW-1:0];
      low_r <= dividend[QUO_W-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      if (stp_r == LAST_STEP) begin
        res_r <= fin_res;
        sat_r <= fin_sat;
      end else begin
        rem_r <= ge ? VW'(rem2 - {1'b0, v_r}) : rem2[VW-1:0];
        low_r <= low_r << 1;
        quo_r <= {quo_r[QUO_W-2:0], ge};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

@@ rtl/core/quaternion_accumulate_renorm.sv @@
// Quaternion accumulator: composes each increment into the stored orientation.
// Plain item: its 16 terms go through one multiplier.
// Renormalizing item: adds 4 squares, a 17-step root and 4 divides.
// One item at a time; the next is taken once the result is registered.
// Sync reset: orientation to identity, step counter 0, interval 97, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quaternion_accumulate_renorm #(
  parameter int FRAC_BITS = qar_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qar_in_if.sink     in_ch,
  qar_out_if.source  out_ch,
  qar_cfg_if.sink    cfg_ch
);
  import qar_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COMP   = 3'd1;
  localparam logic [2:0] S_CWAIT  = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_SQWAIT = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam q_t ONE_Q = (FRAC_BITS >= Q_W - 1) ? q_t'(Q_MAX) : q_t'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(Q_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(Q_MIN);

  logic [2:0]            state_r;
  q_t                    orient_r [4];
  q_t                    delta_r  [4];
  q_t                    q_r      [4];
  logic [3:0]            iss_r;
  logic [1:0]            wr_idx_r;
  logic [1:0]            dv_idx_r;
  logic                  sat_r;
  logic                  renorm_r;
  logic [INTERVAL_W-1:0] step_cnt_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic                  out_valid_r;
  q_t                    out_x_r;
  q_t                    out_y_r;
  q_t                    out_z_r;
  q_t                    out_w_r;
  logic                  out_renorm_r;
  logic                  out_sat_r;

  term_t                   term;
  logic [1:0]              q_rd_idx;
  q_t                      q_rd;
  q_t                      mac_a;
  q_t                      mac_b;
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_done;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shr;
  q_t                      comp_q;
  logic                    comp_sat;
  logic                    comp_wr;
  logic [MAG2_W-1:0]       mag2;
  logic                    sq_start;
  logic                    sq_busy;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    dv_start;
  logic [1:0]              dv_sel;
  logic                    dv_busy;
  logic                    dv_done;
  q_t                      dv_res;
  logic                    dv_sat;
  logic                    out_load;

  // operand select for the shared multiplier
  assign term     = term_sel(iss_r);
  assign q_rd_idx = (state_r == S_SQ) ? iss_r[1:0] : dv_sel;
  assign q_rd     = q_r[q_rd_idx];
  assign mac_a    = (state_r == S_SQ) ? q_rd : orient_r[term.ci];
  assign mac_b    = (state_r == S_SQ) ? q_rd : delta_r[term.di];

  always_comb begin
    mac_ctl.valid = (state_r == S_COMP) || (state_r == S_SQ);
    mac_ctl.clear = iss_r[1:0] == 2'd0;
    mac_ctl.last  = iss_r[1:0] == 2'd3;
    mac_ctl.neg   = (state_r == S_COMP) && term.neg;
  end

  qar_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // round half up, floor shift, clip
  always_comb begin
    rnd = mac_acc + HALF;
    shr = rnd >>> FRAC_BITS;
    if (shr > ACC_MAX) begin
      comp_q   = q_t'(Q_MAX);
      comp_sat = 1'b1;
    end else if (shr < ACC_MIN) begin
      comp_q   = q_t'(Q_MIN);
      comp_sat = 1'b1;
    end else begin
      comp_q   = shr[Q_W-1:0];
      comp_sat = 1'b0;
    end
  end

  assign comp_wr  = mac_done && ((state_r == S_COMP) || (state_r == S_CWAIT));
  assign mag2     = mac_acc[MAG2_W-1:0];
  assign sq_start = (state_r == S_SQWAIT) && mac_done && (mag2 != '0);

  qar_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mag2),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    dv_start = 1'b0;
    dv_sel   = 2'd0;
    if (state_r == S_SQRT) begin
      dv_start = sq_done;
    end else if (state_r == S_DIV) begin
      dv_start = dv_done && (dv_idx_r != 2'd3);
      dv_sel   = dv_idx_r + 2'd1;
    end
  end

  qar_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (q_rd),
    .mag   (sq_root),
    .busy  (dv_busy),
    .done  (dv_done),
    .res   (dv_res),
    .sat   (dv_sat)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      wr_idx_r    <= '0;
      dv_idx_r    <= '0;
      sat_r       <= 1'b0;
      renorm_r    <= 1'b0;
      step_cnt_r  <= '0;
      interval_r  <= RENORM_RESET;
      out_valid_r <= 1'b0;
      orient_r    <= '{q_t'(0), q_t'(0), q_t'(0), ONE_Q};
    end else begin
      if (cfg_ch.valid) begin
        interval_r <= cfg_ch.renorm_interval;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        orient_r    <= q_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (comp_wr) begin
        wr_idx_r <= wr_idx_r + 2'd1;
        sat_r    <= sat_r | comp_sat;
      end
      if (dv_done) begin
        sat_r <= sat_r | dv_sat;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            iss_r    <= '0;
            wr_idx_r <= '0;
            sat_r    <= 1'b0;
            renorm_r <= 1'b0;
            state_r  <= S_COMP;
          end
        end
        S_COMP: begin
          iss_r <= iss_r + 4'd1;
          if (iss_r == 4'd15) begin
            state_r <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (mac_done && (wr_idx_r == 2'd3)) begin
            iss_r <= '0;
            if (step_cnt_r >= interval_r) begin
              step_cnt_r <= '0;
              state_r    <= S_SQ;
            end else begin
              step_cnt_r <= step_cnt_r + 1'b1;
              state_r    <= S_DONE;
            end
          end
        end
        S_SQ: begin
          iss_r <= iss_r + 4'd1;
          if (iss_r[1:0] == 2'd3) begin
            state_r <= S_SQWAIT;
          end
        end
        S_SQWAIT: begin
          if (mac_done) begin
            // zero magnitude: keep the composed value as is
            state_r <= (mag2 == '0) ? S_DONE : S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            dv_idx_r <= '0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            if (dv_idx_r == 2'd3) begin
              renorm_r <= 1'b1;
              state_r  <= S_DONE;
            end else begin
              dv_idx_r <= dv_idx_r + 2'd1;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_ch.valid) begin
      delta_r[0] <= in_ch.delta_x;
      delta_r[1] <= in_ch.delta_y;
      delta_r[2] <= in_ch.delta_z;
      delta_r[3] <= in_ch.delta_w;
    end
    if (comp_wr) begin
      q_r[wr_idx_r] <= comp_q;
    end
    if (dv_done) begin
      q_r[dv_idx_r] <= dv_res;
    end
    if (out_load) begin
      out_x_r      <= q_r[0];
      out_y_r      <= q_r[1];
      out_z_r      <= q_r[2];
      out_w_r      <= q_r[3];
      out_renorm_r <= renorm_r;
      out_sat_r    <= sat_r;
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.orient_x     = out_x_r;
  assign out_ch.orient_y     = out_y_r;
  assign out_ch.orient_z     = out_z_r;
  assign out_ch.orient_w     = out_w_r;
  assign out_ch.renormalized = out_renorm_r;
  assign out_ch.saturated    = out_sat_r;

  `ASSERT_IMPL(a_idle_units_quiet, in_ch.ready, !sq_busy && !dv_busy)
  `ASSERT_IMPL(a_mac_done_phase, mac_done, state_r == S_COMP || state_r == S_CWAIT || state_r == S_SQWAIT)
  `ASSERT_IMPL(a_div_done_phase, dv_done, state_r == S_DIV)
  `ASSERT_NEXT(a_load_to_idle, out_load, state_r == S_IDLE && out_valid_r)

endmodule

`default_nettype wire

@@ verif/tb_quaternion_accumulate_renorm.sv @@
`timescale 1ns / 1ps
// Self-checking bench for quaternion_accumulate_renorm: predicted orientations vs. output beats

module tb_quaternion_accumulate_renorm;
  import qar_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int ONE_Q       = 1 << FRAC;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 150;
  localparam int DRAIN_TAIL  = 150;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    q_t   w;
    logic renormalized;
    logic saturated;
  } orient_beat_t;

  logic clk;
  logic rst_n;

  qar_in_if  in_if ();
  qar_out_if out_if ();
  qar_cfg_if cfg_if ();

  quaternion_accumulate_renorm u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor state
  q_t                    orient_m [4];
  logic [INTERVAL_W-1:0] step_cnt_m;
  logic [INTERVAL_W-1:0] interval_m;
  orient_beat_t          orient_q [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int beat_count     = 0;
  bit bursts_on      = 1'b1;
  bit hold_req       = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clip_q(input longint v, inout bit sat);
    if (v > Q_MAX) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // floor(sqrt(n)) for n up to 2^32
  function automatic longint floor_root(input longint n);
    longint r;
    longint t;
    int     b;
    r = 0;
    for (b = 16; b >= 0; b--) begin
      t = r + (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // compose the increment into the orientation, renormalize on schedule
  function automatic orient_beat_t compose_step(input q_t dx, input q_t dy, input q_t dz,
                                                input q_t dw);
    longint       c [4];
    longint       d [4];
    longint       acc [4];
    longint       q [4];
    longint       mag2;
    longint       mag;
    longint       num;
    longint       a;
    longint       r;
    bit           sat;
    bit           ren;
    int           i;
    orient_beat_t res;
    sat = 1'b0;
    ren = 1'b0;
    d[0] = dx;
    d[1] = dy;
    d[2] = dz;
    d[3] = dw;
    for (i = 0; i < 4; i++) c[i] = orient_m[i];
    acc[0] = d[0] * c[3] + c[0] * d[3] + c[1] * d[2] - c[2] * d[1];
    acc[1] = d[1] * c[3] + c[1] * d[3] + c[2] * d[0] - c[0] * d[2];
    acc[2] = d[2] * c[3] + c[2] * d[3] + c[0] * d[1] - c[1] * d[0];
    acc[3] = d[3] * c[3] - d[0] * c[0] - d[1] * c[1] - d[2] * c[2];
    // round half up, floor shift, clip
    for (i = 0; i < 4; i++) q[i] = clip_q((acc[i] + (longint'(1) << (FRAC - 1))) >>> FRAC, sat);
    if (step_cnt_m >= interval_m) begin
      step_cnt_m = '0;
      mag2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
      if (mag2 != 0) begin
        mag = floor_root(mag2);
        ren = 1'b1;
        for (i = 0; i < 4; i++) begin
          num  = q[i] * (longint'(1) << FRAC);
          a    = (num < 0) ? -num : num;
          r    = (2 * a + mag) / (2 * mag);   // half away from zero
          q[i] = clip_q((num < 0) ? -r : r, sat);
        end
      end
    end else begin
      step_cnt_m = step_cnt_m + 1'b1;
    end
    for (i = 0; i < 4; i++) orient_m[i] = q_t'(q[i]);
    res.x            = q_t'(q[0]);
    res.y            = q_t'(q[1]);
    res.z            = q_t'(q[2]);
    res.w            = q_t'(q[3]);
    res.renormalized = ren;
    res.saturated    = sat;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("beat %0d: %s expected %0d, got %0d", beat_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    orient_beat_t want_beat;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (orient_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("beat %0d: output beat with nothing pending", beat_count);
      end else begin
        want_beat = orient_q.pop_front();
        check_field("orient_x", want_beat.x, out_if.orient_x);
        check_field("orient_y", want_beat.y, out_if.orient_y);
        check_field("orient_z", want_beat.z, out_if.orient_z);
        check_field("orient_w", want_beat.w, out_if.orient_w);
        check_field("renormalized", want_beat.renormalized, out_if.renormalized);
        check_field("saturated", want_beat.saturated, out_if.saturated);
      end
      beat_count++;
    end
  end

  // output-side stalls; long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_delta(input q_t dx, input q_t dy, input q_t dz, input q_t dw);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.delta_x = dx;
    in_if.delta_y = dy;
    in_if.delta_z = dz;
    in_if.delta_w = dw;
    do @(posedge clk); while (!in_if.ready);
    orient_q.push_back(compose_step(dx, dy, dz, dw));
    @(negedge clk);
  endtask

  // mostly unit-length increments; some full-range noise and corner values
  task automatic send_random();
    q_t     v [4];
    longint s;
    int     kind;
    int     span;
    int     i;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      span = $urandom_range(0, 1) ? 256 : 4096;
      for (i = 0; i < 3; i++) v[i] = q_t'(int'($urandom_range(0, 2 * span)) - span);
      s    = longint'(v[0]) * v[0] + longint'(v[1]) * v[1] + longint'(v[2]) * v[2];
      v[3] = q_t'(floor_root((longint'(1) << (2 * FRAC)) - s));
      if ($urandom_range(0, 7) == 0) v[3] = -v[3];
    end else if (kind == 7) begin
      for (i = 0; i < 4; i++) v[i] = q_t'($urandom);
    end else if (kind == 8) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 4))
          0:       v[i] = q_t'(Q_MAX);
          1:       v[i] = q_t'(Q_MIN);
          2:       v[i] = '0;
          3:       v[i] = q_t'(ONE_Q);
          default: v[i] = q_t'(-ONE_Q);
        endcase
      end
    end else begin
      v[0] = '0;
      v[1] = '0;
      v[2] = '0;
      v[3] = $urandom_range(0, 1) ? q_t'(ONE_Q) : q_t'(-ONE_Q);
    end
    send_delta(v[0], v[1], v[2], v[3]);
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    while (orient_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    drain_results();
    cfg_if.valid           = 1'b1;
    cfg_if.renorm_interval = value;
    do @(posedge clk); while (!cfg_if.ready);
    interval_m = value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // identity, each field at both extremes, then all-min and all-max to force clipping
  task automatic test_field_extremes();
    send_delta('0, '0, '0, q_t'(ONE_Q));
    send_delta(q_t'(Q_MAX), '0, '0, '0);
    send_delta(q_t'(Q_MIN), '0, '0, '0);
    send_delta('0, q_t'(Q_MAX), '0, '0);
    send_delta('0, q_t'(Q_MIN), '0, '0);
    send_delta('0, '0, q_t'(Q_MAX), '0);
    send_delta('0, '0, q_t'(Q_MIN), '0);
    send_delta('0, '0, '0, q_t'(Q_MAX));
    send_delta('0, '0, '0, q_t'(Q_MIN));
    send_delta(q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN), q_t'(Q_MIN));
    send_delta(q_t'(Q_MAX), q_t'(Q_MAX), q_t'(Q_MAX), q_t'(Q_MAX));
  endtask

  // interval of zero: every composition renormalizes
  task automatic test_every_step_renorm();
    write_interval('0);
    send_delta(q_t'(Q_MAX), q_t'(Q_MIN), q_t'(Q_MAX), q_t'(Q_MIN));
    send_random();
    send_random();
  endtask

  // dropping the interval below the running count renormalizes on the next item
  task automatic test_interval_lowered();
    write_interval(7'd127);
    repeat (4) send_random();
    write_interval(7'd2);
    repeat (2) send_random();
  endtask

  task automatic test_output_backpressure();
    bursts_on = 1'b0;
    hold_req  = 1'b1;
    repeat (8) send_random();
    bursts_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_phases();
    int p;
    for (p = 0; p < 6; p++) begin
      if (p == 5) bursts_on = 1'b0;
      case (p)
        0:       write_interval(7'd1);
        1:       write_interval(7'd127);
        4:       write_interval(RENORM_RESET);
        default: write_interval(INTERVAL_W'($urandom_range(1, 127)));
      endcase
      repeat (PHASE_BEATS) send_random();
    end
  endtask

  // zero orientation is absorbing, so this runs last
  task automatic test_zero_magnitude();
    write_interval(7'd1);
    send_delta('0, '0, '0, '0);
    send_delta('0, '0, '0, '0);
    send_random();
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.delta_x          = '0;
    in_if.delta_y          = '0;
    in_if.delta_z          = '0;
    in_if.delta_w          = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.renorm_interval = '0;
    orient_m[0]            = '0;
    orient_m[1]            = '0;
    orient_m[2]            = '0;
    orient_m[3]            = q_t'(ONE_Q);
    step_cnt_m             = '0;
    interval_m             = RENORM_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_every_step_renorm();
    test_interval_lowered();
    test_output_backpressure();
    test_random_phases();
    test_zero_magnitude();

    drain_results();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
